>>> hw/rtl/rc5_pkg.sv
package rc5_pkg;

    // default sizes, the top level hands them down as parameters
    localparam int DEF_MAX_KEY_BYTES = 256;
    localparam int DEF_MAX_ROUNDS    = 255;
    localparam int MAX_WORD_BITS     = 64;

    // widths of command fields, sized for the largest legal parameters
    localparam int KS_POS_W  = 9;
    localparam int KW_ADDR_W = 7;
    localparam int RK_IDX_W  = 10;
    localparam int ROW_W     = 8;

    // word size codes
    localparam logic [1:0] WS_16 = 2'd0;
    localparam logic [1:0] WS_32 = 2'd1;
    localparam logic [1:0] WS_64 = 2'd2;

    // transaction actions
    localparam logic [2:0] ACT_STORE   = 3'd0;
    localparam logic [2:0] ACT_EXPAND  = 3'd1;
    localparam logic [2:0] ACT_LOAD_IV = 3'd2;
    localparam logic [2:0] ACT_ENCRYPT = 3'd3;
    localparam logic [2:0] ACT_DECRYPT = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_WORD_SIZE  = 3'd0;
    localparam logic [2:0] REG_ROUNDS     = 3'd1;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd2;
    localparam logic [2:0] REG_CHAIN_MODE = 3'd3;

    // magic constants
    localparam logic [63:0] P64 = 64'hB7E151628AED2A6B;
    localparam logic [63:0] Q64 = 64'h9E3779B97F4A7C15;
    localparam logic [31:0] P32 = 32'hb7e15163;
    localparam logic [31:0] Q32 = 32'h9e3779b9;
    localparam logic [15:0] P16 = 16'hb7e1;
    localparam logic [15:0] Q16 = 16'h9e37;
    localparam logic [5:0]  MIX_ROT = 6'd3;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_STORE,
        DP_EXPAND,
        DP_LOAD_IV,
        DP_LOAD_ENC,
        DP_LOAD_DEC,
        DP_PK_ACC,
        DP_INIT_STEP,
        DP_MX_A,
        DP_MX_S,
        DP_MX_B,
        DP_EN_PRE,
        DP_EN_A,
        DP_EN_B,
        DP_DE_B,
        DP_DE_A,
        DP_FIN_ENC,
        DP_FIN_DEC,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic                   rk_rd;
        logic [ROW_W-1:0]       rk_row;
        logic [RK_IDX_W-1:0]    rk_idx;
        logic                   kw_rd;
        logic [KW_ADDR_W-1:0]   kw_addr;
        logic                   ks_rd;
        logic [KS_POS_W-1:0]    ks_pos;
        logic [2:0]             byte_k;
        logic                   byte_ok;
        logic                   pk_last;
    } dp_cmd_t;

    // word size code after the width cap
    function automatic logic [1:0] eff_ws(input logic [1:0] ws);
        logic [1:0] r;
        r = ws;
        if (ws != WS_16 && ws != WS_32) begin
            r = WS_64;
        end
        if (r == WS_64 && MAX_WORD_BITS < 64) begin
            r = (MAX_WORD_BITS >= 32) ? WS_32 : WS_16;
        end
        if (r == WS_32 && MAX_WORD_BITS < 32) begin
            r = WS_16;
        end
        return r;
    endfunction

    function automatic logic [63:0] wmask(input logic [1:0] ws);
        logic [63:0] m;
        case (ws)
            WS_16:   m = 64'h000000000000FFFF;
            WS_32:   m = 64'h00000000FFFFFFFF;
            default: m = 64'hFFFFFFFFFFFFFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] n,
                                         input logic [1:0] ws);
        logic [31:0]  t16;
        logic [63:0]  t32;
        logic [127:0] t64;
        logic [63:0]  r;
        t16 = {x[15:0], x[15:0]} << n[3:0];
        t32 = {x[31:0], x[31:0]} << n[4:0];
        t64 = {x, x} << n;
        case (ws)
            WS_16:   r = {48'd0, t16[31:16]};
            WS_32:   r = {32'd0, t32[63:32]};
            default: r = t64[127:64];
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input logic [5:0] n,
                                         input logic [1:0] ws);
        logic [31:0]  t16;
        logic [63:0]  t32;
        logic [127:0] t64;
        logic [63:0]  r;
        t16 = {x[15:0], x[15:0]} >> n[3:0];
        t32 = {x[31:0], x[31:0]} >> n[4:0];
        t64 = {x, x} >> n;
        case (ws)
            WS_16:   r = {48'd0, t16[15:0]};
            WS_32:   r = {32'd0, t32[31:0]};
            default: r = t64[63:0];
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/rc5_if.sv
interface rc5_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  key_index;
    logic [7:0]  key_byte;
    logic [63:0] word_a;
    logic [63:0] word_b;

    modport source (output valid, action, key_index, key_byte, word_a, word_b, input ready);
    modport sink (input valid, action, key_index, key_byte, word_a, word_b, output ready);
endinterface

interface rc5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_a;
    logic [63:0] result_b;

    modport source (output valid, result_a, result_b, input ready);
    modport sink (input valid, result_a, result_b, output ready);
endinterface

>>> hw/rtl/rc5_dp.sv
module rc5_dp #(
    parameter int MAX_KEY_BYTES = rc5_pkg::DEF_MAX_KEY_BYTES,
    parameter int MAX_ROUNDS    = rc5_pkg::DEF_MAX_ROUNDS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rc5_pkg::dp_cmd_t cmd,
    input  logic [1:0]       ws,
    input  logic             chain_mode,
    input  logic [7:0]       key_index,
    input  logic [7:0]       key_byte,
    input  logic [63:0]      word_a,
    input  logic [63:0]      word_b,
    output logic [63:0]      result_a,
    output logic [63:0]      result_b
);

    localparam int KWD  = (MAX_KEY_BYTES + 1) / 2;
    localparam int ROWS = MAX_ROUNDS + 1;
    localparam int KSA  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KWA  = (KWD > 1) ? $clog2(KWD) : 1;
    localparam int RKA  = $clog2(ROWS);

    logic [7:0]  ks_mem [MAX_KEY_BYTES];
    logic [63:0] kw_mem [KWD];
    logic [63:0] rke_mem [ROWS];
    logic [63:0] rko_mem [ROWS];

    logic [7:0]  ks_q;
    logic [63:0] kw_q, rke_q, rko_q;

    logic [63:0] a_reg, a_next, b_reg, b_next, s_reg, s_next;
    logic [5:0]  amt_reg, amt_next;
    logic [63:0] acc_reg, acc_next, pval_reg, pval_next;
    logic [63:0] cin_a_reg, cin_a_next, cin_b_reg, cin_b_next;
    logic [63:0] res_a_reg, res_a_next, res_b_reg, res_b_next;
    logic [63:0] chain_a_reg, chain_a_next, chain_b_reg, chain_b_next;

    logic [63:0] m, in_a, in_b, acc_sum, mx_a, rk_sel, rk_wdata;
    logic        rk_we, kw_we;
    logic [63:0] kw_wdata;
    logic [RKA-1:0] rk_wrow;
    logic [63:0] p_init, q_step;

    always_comb
    begin
        m = rc5_pkg::wmask(ws);
        in_a = word_a & m;
        in_b = word_b & m;
        case (ws)
            rc5_pkg::WS_16:
            begin
                p_init = {48'd0, rc5_pkg::P16};
                q_step = {48'd0, rc5_pkg::Q16};
            end
            rc5_pkg::WS_32:
            begin
                p_init = {32'd0, rc5_pkg::P32};
                q_step = {32'd0, rc5_pkg::Q32};
            end
            default:
            begin
                p_init = rc5_pkg::P64;
                q_step = rc5_pkg::Q64;
            end
        endcase
        rk_sel  = cmd.rk_idx[0] ? rko_q : rke_q;
        mx_a    = rc5_pkg::rotl((rk_sel + a_reg + b_reg) & m, rc5_pkg::MIX_ROT, ws);
        acc_sum = acc_reg | ({56'd0, cmd.byte_ok ? ks_q : 8'd0} << {cmd.byte_k, 3'd0});

        a_next = a_reg;
        b_next = b_reg;
        s_next = s_reg;
        amt_next = amt_reg;
        acc_next = acc_reg;
        pval_next = pval_reg;
        cin_a_next = cin_a_reg;
        cin_b_next = cin_b_reg;
        res_a_next = res_a_reg;
        res_b_next = res_b_reg;
        chain_a_next = chain_a_reg;
        chain_b_next = chain_b_reg;
        rk_we = 1'b0;
        rk_wdata = pval_reg;
        kw_we = 1'b0;
        kw_wdata = acc_sum;

        case (cmd.op)
            rc5_pkg::DP_EXPAND:
            begin
                acc_next = '0;
                pval_next = p_init;
                a_next = '0;
                b_next = '0;
            end
            rc5_pkg::DP_LOAD_IV:
            begin
                chain_a_next = in_a;
                chain_b_next = in_b;
            end
            rc5_pkg::DP_LOAD_ENC:
            begin
                a_next = chain_mode ? (in_a ^ (chain_a_reg & m)) : in_a;
                b_next = chain_mode ? (in_b ^ (chain_b_reg & m)) : in_b;
            end
            rc5_pkg::DP_LOAD_DEC:
            begin
                a_next = in_a;
                b_next = in_b;
                cin_a_next = in_a;
                cin_b_next = in_b;
            end
            rc5_pkg::DP_PK_ACC:
            begin
                acc_next = cmd.pk_last ? 64'd0 : acc_sum;
                kw_we = cmd.pk_last;
            end
            rc5_pkg::DP_INIT_STEP:
            begin
                rk_we = 1'b1;
                pval_next = (pval_reg + q_step) & m;
            end
            rc5_pkg::DP_MX_A:
            begin
                rk_we = 1'b1;
                rk_wdata = mx_a;
                a_next = mx_a;
            end
            rc5_pkg::DP_MX_S:
            begin
                s_next = (kw_q + a_reg + b_reg) & m;
                amt_next = 6'(a_reg + b_reg);
            end
            rc5_pkg::DP_MX_B:
            begin
                b_next = rc5_pkg::rotl(s_reg, amt_reg, ws);
                kw_we = 1'b1;
                kw_wdata = b_next;
            end
            rc5_pkg::DP_EN_PRE:
            begin
                a_next = (a_reg + rke_q) & m;
                b_next = (b_reg + rko_q) & m;
            end
            rc5_pkg::DP_EN_A:
                a_next = (rc5_pkg::rotl(a_reg ^ b_reg, b_reg[5:0], ws) + rke_q) & m;
            rc5_pkg::DP_EN_B:
                b_next = (rc5_pkg::rotl(b_reg ^ a_reg, a_reg[5:0], ws) + rko_q) & m;
            rc5_pkg::DP_DE_B:
                b_next = rc5_pkg::rotr((b_reg - rko_q) & m, a_reg[5:0], ws) ^ a_reg;
            rc5_pkg::DP_DE_A:
                a_next = rc5_pkg::rotr((a_reg - rke_q) & m, b_reg[5:0], ws) ^ b_reg;
            rc5_pkg::DP_FIN_ENC:
            begin
                if (chain_mode)
                begin
                    chain_a_next = a_reg;
                    chain_b_next = b_reg;
                end
            end
            rc5_pkg::DP_FIN_DEC:
            begin
                a_next = (a_reg - rke_q) & m;
                b_next = (b_reg - rko_q) & m;
                if (chain_mode)
                begin
                    a_next = (a_next ^ chain_a_reg) & m;
                    b_next = (b_next ^ chain_b_reg) & m;
                    chain_a_next = cin_a_reg;
                    chain_b_next = cin_b_reg;
                end
            end
            rc5_pkg::DP_OUT:
            begin
                res_a_next = a_reg;
                res_b_next = b_reg;
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
        rk_wrow = cmd.rk_idx[RKA:1];
    end

    // key store, key words and round key halves
    always_ff @(posedge clk)
    begin
        if (cmd.op == rc5_pkg::DP_STORE && {1'b0, key_index} < 9'(MAX_KEY_BYTES))
        begin
            ks_mem[key_index[KSA-1:0]] <= key_byte;
        end
        if (cmd.ks_rd && cmd.ks_pos < 9'(MAX_KEY_BYTES))
        begin
            ks_q <= ks_mem[cmd.ks_pos[KSA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (kw_we)
        begin
            kw_mem[cmd.kw_addr[KWA-1:0]] <= kw_wdata;
        end
        if (cmd.kw_rd)
        begin
            kw_q <= kw_mem[cmd.kw_addr[KWA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_we && !cmd.rk_idx[0])
        begin
            rke_mem[rk_wrow] <= rk_wdata;
        end
        if (cmd.rk_rd)
        begin
            rke_q <= rke_mem[cmd.rk_row[RKA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_we && cmd.rk_idx[0])
        begin
            rko_mem[rk_wrow] <= rk_wdata;
        end
        if (cmd.rk_rd)
        begin
            rko_q <= rko_mem[cmd.rk_row[RKA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        s_reg <= s_next;
        amt_reg <= amt_next;
        acc_reg <= acc_next;
        pval_reg <= pval_next;
        cin_a_reg <= cin_a_next;
        cin_b_reg <= cin_b_next;
        res_a_reg <= res_a_next;
        res_b_reg <= res_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_a_reg <= '0;
            chain_b_reg <= '0;
        end
        else
        begin
            chain_a_reg <= chain_a_next;
            chain_b_reg <= chain_b_next;
        end
    end

    assign result_a = res_a_reg;
    assign result_b = res_b_reg;

endmodule

>>> hw/rtl/rc5_ctrl.sv
module rc5_ctrl #(
    parameter int MAX_KEY_BYTES = rc5_pkg::DEF_MAX_KEY_BYTES,
    parameter int MAX_ROUNDS    = rc5_pkg::DEF_MAX_ROUNDS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       action,
    input  logic [1:0]       ws,
    input  logic [7:0]       rounds,
    input  logic [7:0]       key_length,
    output logic             out_valid,
    input  logic             out_ready,
    output rc5_pkg::dp_cmd_t cmd
);

    localparam int KWD = (MAX_KEY_BYTES + 1) / 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PK_RD, ST_PK_ACC, ST_INIT, ST_MX_RD, ST_MX_A, ST_MX_S, ST_MX_B,
        ST_EN_PRE, ST_EN_A, ST_EN_B, ST_DE_B, ST_DE_A, ST_FIN_ENC, ST_FIN_DEC, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [8:0]  pos_reg;
    logic [2:0]  k_reg;
    logic [6:0]  j_reg;
    logic [9:0]  i_reg;
    logic [11:0] step_reg;
    logic [7:0]  rnd_reg;
    logic        out_valid_reg;

    logic        accept, out_free;
    logic [7:0]  r_sat;
    logic [8:0]  b_sat;
    logic [2:0]  u_last;
    logic [1:0]  lgu;
    logic [9:0]  c_raw, c_val, t_val, mx;
    logic [11:0] n_val;

    always_comb
    begin
        r_sat = (rounds > 8'(MAX_ROUNDS)) ? 8'(MAX_ROUNDS) : rounds;
        b_sat = ({1'b0, key_length} > 9'(MAX_KEY_BYTES)) ? 9'(MAX_KEY_BYTES)
                                                           : {1'b0, key_length};
        case (ws)
            rc5_pkg::WS_16:
            begin
                u_last = 3'd1;
                lgu = 2'd1;
            end
            rc5_pkg::WS_32:
            begin
                u_last = 3'd3;
                lgu = 2'd2;
            end
            default:
            begin
                u_last = 3'd7;
                lgu = 2'd3;
            end
        endcase
        c_raw = ({1'b0, b_sat} + {7'd0, u_last}) >> lgu;
        c_val = (c_raw == 10'd0) ? 10'd1 : c_raw;
        if (c_val > 10'(KWD))
        begin
            c_val = 10'(KWD);
        end
        t_val = {1'b0, r_sat, 1'b0} + 10'd2;
        mx = (t_val > c_val) ? t_val : c_val;
        n_val = {2'd0, mx} + {1'b0, mx, 1'b0};
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.op = rc5_pkg::DP_NOP;
        cmd.ks_pos = pos_reg;
        cmd.byte_k = k_reg;
        cmd.kw_addr = j_reg;
        cmd.rk_idx = i_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        rc5_pkg::ACT_STORE:   cmd.op = rc5_pkg::DP_STORE;
                        rc5_pkg::ACT_EXPAND:  cmd.op = rc5_pkg::DP_EXPAND;
                        rc5_pkg::ACT_LOAD_IV: cmd.op = rc5_pkg::DP_LOAD_IV;
                        rc5_pkg::ACT_ENCRYPT:
                        begin
                            cmd.op = rc5_pkg::DP_LOAD_ENC;
                            cmd.rk_rd = 1'b1;
                            cmd.rk_row = '0;
                        end
                        rc5_pkg::ACT_DECRYPT:
                        begin
                            cmd.op = rc5_pkg::DP_LOAD_DEC;
                            cmd.rk_rd = 1'b1;
                            cmd.rk_row = r_sat;
                        end
                        default: cmd.op = rc5_pkg::DP_NOP;
                    endcase
                end
            end
            ST_PK_RD: cmd.ks_rd = 1'b1;
            ST_PK_ACC:
            begin
                cmd.op = rc5_pkg::DP_PK_ACC;
                cmd.byte_ok = (pos_reg < b_sat);
                cmd.pk_last = (k_reg == u_last);
            end
            ST_INIT: cmd.op = rc5_pkg::DP_INIT_STEP;
            ST_MX_RD:
            begin
                cmd.rk_rd = 1'b1;
                cmd.rk_row = i_reg[8:1];
                cmd.kw_rd = 1'b1;
            end
            ST_MX_A: cmd.op = rc5_pkg::DP_MX_A;
            ST_MX_S: cmd.op = rc5_pkg::DP_MX_S;
            ST_MX_B: cmd.op = rc5_pkg::DP_MX_B;
            ST_EN_PRE:
            begin
                cmd.op = rc5_pkg::DP_EN_PRE;
                cmd.rk_rd = (r_sat != 8'd0);
                cmd.rk_row = 8'd1;
            end
            ST_EN_A: cmd.op = rc5_pkg::DP_EN_A;
            ST_EN_B:
            begin
                cmd.op = rc5_pkg::DP_EN_B;
                cmd.rk_rd = (rnd_reg != r_sat);
                cmd.rk_row = rnd_reg + 8'd1;
            end
            ST_DE_B: cmd.op = rc5_pkg::DP_DE_B;
            ST_DE_A:
            begin
                cmd.op = rc5_pkg::DP_DE_A;
                cmd.rk_rd = 1'b1;
                cmd.rk_row = rnd_reg - 8'd1;
            end
            ST_FIN_ENC: cmd.op = rc5_pkg::DP_FIN_ENC;
            ST_FIN_DEC: cmd.op = rc5_pkg::DP_FIN_DEC;
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = rc5_pkg::DP_OUT;
                end
            end
            default: cmd.op = rc5_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg <= '0;
            k_reg <= '0;
            j_reg <= '0;
            i_reg <= '0;
            step_reg <= '0;
            rnd_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (action)
                            rc5_pkg::ACT_EXPAND:
                            begin
                                pos_reg <= '0;
                                k_reg <= '0;
                                j_reg <= '0;
                                state_reg <= ST_PK_RD;
                            end
                            rc5_pkg::ACT_ENCRYPT:
                            begin
                                rnd_reg <= 8'd1;
                                state_reg <= ST_EN_PRE;
                            end
                            rc5_pkg::ACT_DECRYPT:
                            begin
                                rnd_reg <= r_sat;
                                state_reg <= (r_sat == 8'd0) ? ST_FIN_DEC : ST_DE_B;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_PK_RD: state_reg <= ST_PK_ACC;
                ST_PK_ACC:
                begin
                    pos_reg <= pos_reg + 9'd1;
                    state_reg <= ST_PK_RD;
                    if (k_reg == u_last)
                    begin
                        k_reg <= '0;
                        if ({3'd0, j_reg} == c_val - 10'd1)
                        begin
                            i_reg <= '0;
                            state_reg <= ST_INIT;
                        end
                        else
                        begin
                            j_reg <= j_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                ST_INIT:
                begin
                    if (i_reg == t_val - 10'd1)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                        step_reg <= '0;
                        state_reg <= ST_MX_RD;
                    end
                    else
                    begin
                        i_reg <= i_reg + 10'd1;
                    end
                end
                ST_MX_RD: state_reg <= ST_MX_A;
                ST_MX_A:  state_reg <= ST_MX_S;
                ST_MX_S:  state_reg <= ST_MX_B;
                ST_MX_B:
                begin
                    if (step_reg == n_val - 12'd1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 12'd1;
                        i_reg <= (i_reg == t_val - 10'd1) ? 10'd0 : i_reg + 10'd1;
                        j_reg <= ({3'd0, j_reg} == c_val - 10'd1) ? 7'd0 : j_reg + 7'd1;
                        state_reg <= ST_MX_RD;
                    end
                end
                ST_EN_PRE: state_reg <= (r_sat == 8'd0) ? ST_FIN_ENC : ST_EN_A;
                ST_EN_A:   state_reg <= ST_EN_B;
                ST_EN_B:
                begin
                    if (rnd_reg == r_sat)
                    begin
                        state_reg <= ST_FIN_ENC;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 8'd1;
                        state_reg <= ST_EN_A;
                    end
                end
                ST_DE_B: state_reg <= ST_DE_A;
                ST_DE_A:
                begin
                    if (rnd_reg == 8'd1)
                    begin
                        state_reg <= ST_FIN_DEC;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg - 8'd1;
                        state_reg <= ST_DE_B;
                    end
                end
                ST_FIN_ENC: state_reg <= ST_OUT;
                ST_FIN_DEC: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_cipher_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == rc5_pkg::ACT_ENCRYPT || action == rc5_pkg::ACT_DECRYPT))
        |=> (state_reg != ST_IDLE))
        else $error("cipher transaction did not start");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> out_valid_reg)
        else $error("result not presented");

    a_mix_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MX_A) |-> (i_reg < t_val))
        else $error("round key index out of range");

    a_key_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MX_B || state_reg == ST_PK_ACC) |-> ({3'd0, j_reg} < c_val))
        else $error("key word index out of range");

endmodule

>>> hw/rtl/rc5_block_cipher_cbc_core.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    action, key_index, key_byte, word_a, word_b
// out_ch    out  valid/ready    result_a, result_b
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// encrypt adds the first round key pair, runs the rounds, then updates the chain and the result:
//   one half round per cycle through the rotate and add logic
// decrypt runs rounds in reverse; key store, chain load and unused actions end at once
// expand packs the key words, fills the schedule, then mixes through the single mixing unit
// reset clears control and the chain block; key and round key memories are unset
// a waiting result does not block the next transaction; a new result stalls until taken
module rc5_block_cipher_cbc_core #(
    parameter int MAX_KEY_BYTES = rc5_pkg::DEF_MAX_KEY_BYTES,
    parameter int MAX_ROUNDS    = rc5_pkg::DEF_MAX_ROUNDS
) (
    input  logic        clk,
    input  logic        rst_n,
    rc5_in_if.sink      in_ch,
    rc5_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration registers
    logic [1:0] word_size_reg;
    logic [7:0] rounds_reg;
    logic [7:0] key_length_reg;
    logic       chain_mode_reg;
    logic [1:0] ws;

    rc5_pkg::dp_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_size_reg <= rc5_pkg::WS_32;
            rounds_reg <= 8'd12;
            key_length_reg <= 8'd16;
            chain_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rc5_pkg::REG_WORD_SIZE:  word_size_reg <= cfg_data[1:0];
                rc5_pkg::REG_ROUNDS:     rounds_reg <= cfg_data;
                rc5_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_data;
                rc5_pkg::REG_CHAIN_MODE: chain_mode_reg <= cfg_data[0];
                default:                 rounds_reg <= rounds_reg;
            endcase
        end
    end

    // word size after the cap
    assign ws = rc5_pkg::eff_ws(word_size_reg);

    // sequencer: key packing, schedule fill, mixing and round stepping
    rc5_ctrl #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .MAX_ROUNDS    (MAX_ROUNDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .action     (in_ch.action),
        .ws         (ws),
        .rounds     (rounds_reg),
        .key_length (key_length_reg),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .cmd        (cmd)
    );

    // memories, block words, chain block and the result register
    rc5_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .MAX_ROUNDS    (MAX_ROUNDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .ws         (ws),
        .chain_mode (chain_mode_reg),
        .key_index  (in_ch.key_index),
        .key_byte   (in_ch.key_byte),
        .word_a     (in_ch.word_a),
        .word_b     (in_ch.word_b),
        .result_a   (out_ch.result_a),
        .result_b   (out_ch.result_b)
    );

endmodule

>>> tb/sv/tb_rc5_block_cipher_cbc_core.sv
module tb_rc5_block_cipher_cbc_core;
    import rc5_pkg::*;

    localparam int CYCLE_LIMIT  = 10000000;
    localparam int RANDOM_ITEMS = 600;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
    } block_t;

    // one row of the directed table: either a register write or a transaction
    typedef struct {
        bit          is_cfg;
        logic [2:0]  code;
        logic [7:0]  idx;
        logic [7:0]  data;
        logic [63:0] a;
        logic [63:0] b;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    rc5_in_if  in_ch ();
    rc5_out_if out_ch ();

    rc5_block_cipher_cbc_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the cipher state and settings
    logic [7:0]  key_bytes [256];
    bit          key_written [256];
    logic [63:0] key_words_m [128];
    logic [63:0] sched_keys [512];
    int unsigned sched_hi;
    logic [63:0] chain_a;
    logic [63:0] chain_b;
    logic [1:0]  ws_cfg;
    logic [7:0]  rounds_cfg;
    logic [7:0]  keylen_cfg;
    logic        chain_cfg;

    block_t      expected_blocks [$];
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned items_sent;
    bit          no_idle;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned width_bits();
        return (ws_cfg == WS_16) ? 16 : (ws_cfg == WS_32) ? 32 : 64;
    endfunction

    function automatic logic [63:0] width_mask(int unsigned w);
        return (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] rot_left(logic [63:0] x, logic [63:0] n, int unsigned w);
        logic [63:0]  m;
        int unsigned  s;
        m = width_mask(w);
        s = 32'(n % 64'(w));
        x = x & m;
        if (s == 0)
        begin
            return x;
        end
        return ((x << s) | (x >> (w - s))) & m;
    endfunction

    function automatic logic [63:0] rot_right(logic [63:0] x, logic [63:0] n, int unsigned w);
        logic [63:0]  m;
        int unsigned  s;
        m = width_mask(w);
        s = 32'(n % 64'(w));
        x = x & m;
        if (s == 0)
        begin
            return x;
        end
        return ((x >> s) | (x << (w - s))) & m;
    endfunction

    // standard key schedule over the mirrored key bytes
    function automatic void expand_schedule();
        int unsigned  w, u, nb, c, t, n, i, j, k, wi;
        logic [63:0]  m, p, q, sa, sb;
        w  = width_bits();
        m  = width_mask(w);
        u  = w / 8;
        nb = keylen_cfg;
        c  = (nb + u - 1) / u;
        t  = 2 * rounds_cfg + 2;
        if (c == 0)
        begin
            c = 1;
        end
        if (c > 128)
        begin
            c = 128;
        end
        for (k = 0; k < c; k++)
        begin
            key_words_m[k] = '0;
        end
        for (k = nb; k > 0; k--)
        begin
            wi = (k - 1) / u;
            if (wi < c)
            begin
                key_words_m[wi] = ((key_words_m[wi] << 8) + key_bytes[k-1]) & m;
            end
        end
        if (w == 16)
        begin
            p = P16;
            q = Q16;
        end
        else if (w == 32)
        begin
            p = P32;
            q = Q32;
        end
        else
        begin
            p = P64;
            q = Q64;
        end
        sched_keys[0] = p & m;
        for (k = 1; k < t; k++)
        begin
            sched_keys[k] = (sched_keys[k-1] + q) & m;
        end
        n  = 3 * ((t > c) ? t : c);
        i  = 0;
        j  = 0;
        sa = '0;
        sb = '0;
        for (k = 0; k < n; k++)
        begin
            sched_keys[i]  = rot_left(sched_keys[i] + sa + sb, 64'd3, w);
            sa             = sched_keys[i];
            key_words_m[j] = rot_left(key_words_m[j] + sa + sb, sa + sb, w);
            sb             = key_words_m[j];
            i = (i + 1) % t;
            j = (j + 1) % c;
        end
        if (t > sched_hi)
        begin
            sched_hi = t;
        end
    endfunction

    // next state and result for one accepted transaction
    function automatic bit cipher_step(logic [2:0] act, logic [7:0] idx, logic [7:0] kb,
                                       logic [63:0] wa, logic [63:0] wb, output block_t res);
        int unsigned  w, r, i;
        logic [63:0]  m, a, b, ca, cb;
        w = width_bits();
        m = width_mask(w);
        r = rounds_cfg;
        a = wa & m;
        b = wb & m;
        res = '{a: '0, b: '0};
        case (act)
            ACT_STORE:
            begin
                key_bytes[idx]   = kb;
                key_written[idx] = 1'b1;
                return 1'b0;
            end
            ACT_EXPAND:
            begin
                expand_schedule();
                return 1'b0;
            end
            ACT_LOAD_IV:
            begin
                chain_a = a;
                chain_b = b;
                return 1'b0;
            end
            ACT_ENCRYPT:
            begin
                if (chain_cfg)
                begin
                    a = a ^ (chain_a & m);
                    b = b ^ (chain_b & m);
                end
                a = (a + sched_keys[0]) & m;
                b = (b + sched_keys[1]) & m;
                for (i = 1; i <= r; i++)
                begin
                    a = (rot_left(a ^ b, b, w) + sched_keys[2*i]) & m;
                    b = (rot_left(b ^ a, a, w) + sched_keys[2*i+1]) & m;
                end
                if (chain_cfg)
                begin
                    chain_a = a;
                    chain_b = b;
                end
                res = '{a: a, b: b};
                return 1'b1;
            end
            ACT_DECRYPT:
            begin
                ca = a;
                cb = b;
                for (i = r; i > 0; i--)
                begin
                    b = (rot_right((b - sched_keys[2*i+1]) & m, a, w) ^ a) & m;
                    a = (rot_right((a - sched_keys[2*i]) & m, b, w) ^ b) & m;
                end
                a = (a - sched_keys[0]) & m;
                b = (b - sched_keys[1]) & m;
                if (chain_cfg)
                begin
                    a = (a ^ chain_a) & m;
                    b = (b ^ chain_b) & m;
                    chain_a = ca;
                    chain_b = cb;
                end
                res = '{a: a, b: b};
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
        mismatches++;
    endtask

    // cycles a key expansion may still be running after the last result
    function automatic int unsigned busy_cycles();
        int unsigned u, c, t;
        u = width_bits() / 8;
        c = (keylen_cfg + u - 1) / u;
        if (c == 0)
        begin
            c = 1;
        end
        t = 2 * rounds_cfg + 2;
        return 2 * u * c + t + 12 * ((t > c) ? t : c) + 2 * rounds_cfg + 64;
    endfunction

    // one transaction on the input channel, predicted when accepted
    task automatic send_item(logic [2:0] act, logic [7:0] idx, logic [7:0] kb,
                             logic [63:0] wa, logic [63:0] wb);
        int unsigned  gap;
        block_t       res;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.key_index <= idx;
        in_ch.key_byte  <= kb;
        in_ch.word_a    <= wa;
        in_ch.word_b    <= wb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (cipher_step(act, idx, kb, wa, wb, res))
        begin
            expected_blocks.push_back(res);
        end
        if (act <= ACT_DECRYPT)
        begin
            items_sent++;
        end
    endtask

    // let the block fall idle before touching its registers
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_blocks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (busy_cycles()) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_WORD_SIZE:  ws_cfg     = (data[1:0] == 2'd3) ? WS_64 : data[1:0];
            REG_ROUNDS:     rounds_cfg = data;
            REG_KEY_LENGTH: keylen_cfg = data;
            default:        chain_cfg  = data[0];
        endcase
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // result side: random stall per result, then check against the oldest expectation
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        block_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   = 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                report_mismatch("unexpected result", 64'd0, out_ch.result_a);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (out_ch.result_a !== want.a)
                begin
                    report_mismatch("result_a", want.a, out_ch.result_a);
                end
                if (out_ch.result_b !== want.b)
                begin
                    report_mismatch("result_b", want.b, out_ch.result_b);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 18);
            out_ch.ready <= (stall_left == 0);
        end
        else if (!out_ch.ready)
        begin
            if (stall_left == 0)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                stall_left--;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        step_row_t   rows [$];
        bit          in_cfg;
        int unsigned n, k, pick;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_STORE;
        in_ch.key_index = '0;
        in_ch.key_byte  = '0;
        in_ch.word_a    = '0;
        in_ch.word_b    = '0;
        mismatches      = 0;
        cycles          = 0;
        items_sent      = 0;
        no_idle         = 1'b0;
        sched_hi        = 0;
        chain_a         = '0;
        chain_b         = '0;
        ws_cfg          = WS_32;
        rounds_cfg      = 8'd12;
        keylen_cfg      = 8'd16;
        chain_cfg       = 1'b1;
        for (k = 0; k < 256; k++)
        begin
            key_bytes[k]   = '0;
            key_written[k] = 1'b0;
        end
        for (k = 0; k < 128; k++)
        begin
            key_words_m[k] = '0;
        end
        for (k = 0; k < 512; k++)
        begin
            sched_keys[k] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 16-bit ECB, no rounds, empty key
        rows.push_back('{1, REG_WORD_SIZE, 0, 8'(WS_16), 0, 0});
        rows.push_back('{1, REG_ROUNDS, 0, 8'd0, 0, 0});
        rows.push_back('{1, REG_KEY_LENGTH, 0, 8'd0, 0, 0});
        rows.push_back('{1, REG_CHAIN_MODE, 0, 8'd0, 0, 0});
        rows.push_back('{0, ACT_EXPAND, 0, 0, 0, 0});
        rows.push_back('{0, ACT_ENCRYPT, 0, 0, 64'd0, 64'd0});
        rows.push_back('{0, ACT_ENCRYPT, 0, 0, '1, '1});
        rows.push_back('{0, ACT_DECRYPT, 0, 0, '1, 64'd0});
        // key store extremes and the unused actions
        rows.push_back('{0, ACT_STORE, 8'd255, 8'hFF, 0, 0});
        rows.push_back('{0, ACT_STORE, 8'd0, 8'h00, 0, 0});
        rows.push_back('{0, 3'd5, 8'hFF, 8'hFF, '1, '1});
        rows.push_back('{0, 3'd6, 0, 0, 0, 0});
        rows.push_back('{0, 3'd7, 0, 0, 0, 0});
        // selector 3 runs as 64-bit, cbc with a loaded chain value
        rows.push_back('{1, REG_WORD_SIZE, 0, 8'd3, 0, 0});
        rows.push_back('{1, REG_ROUNDS, 0, 8'd1, 0, 0});
        rows.push_back('{1, REG_KEY_LENGTH, 0, 8'd2, 0, 0});
        rows.push_back('{1, REG_CHAIN_MODE, 0, 8'd1, 0, 0});
        rows.push_back('{0, ACT_STORE, 8'd1, 8'hA5, 0, 0});
        rows.push_back('{0, ACT_EXPAND, 0, 0, 0, 0});
        rows.push_back('{0, ACT_LOAD_IV, 0, 0, '1, 64'h0123456789ABCDEF});
        rows.push_back('{0, ACT_ENCRYPT, 0, 0, '1, 64'd0});
        rows.push_back('{0, ACT_DECRYPT, 0, 0, 64'd0, '1});
        // full round count on 64-bit words
        rows.push_back('{1, REG_ROUNDS, 0, 8'd255, 0, 0});
        rows.push_back('{1, REG_KEY_LENGTH, 0, 8'd3, 0, 0});
        rows.push_back('{0, ACT_STORE, 8'd2, 8'h5A, 0, 0});
        rows.push_back('{0, ACT_EXPAND, 0, 0, 0, 0});
        rows.push_back('{0, ACT_ENCRYPT, 0, 0, 64'h8000000000000001, '1});
        rows.push_back('{0, ACT_DECRYPT, 0, 0, '1, 64'h8000000000000001});

        in_cfg = 1'b0;
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                if (!in_cfg)
                begin
                    settle();
                    in_cfg = 1'b1;
                end
                write_reg(rows[i].code, rows[i].data);
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_we <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_item(rows[i].code, rows[i].idx, rows[i].data, rows[i].a, rows[i].b);
            end
        end

        // random phases: new settings, key setup, expand, then a run of blocks
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            write_reg(REG_WORD_SIZE, 8'($urandom_range(0, 3)));
            pick = $urandom_range(0, 9);
            write_reg(REG_ROUNDS,
                      8'((pick == 0) ? 255 : (pick == 1) ? 0 : $urandom_range(1, 16)));
            pick = $urandom_range(0, 9);
            write_reg(REG_KEY_LENGTH, 8'((pick == 0) ? $urandom_range(200, 255) :
                      (pick == 1) ? 0 : $urandom_range(1, 24)));
            write_reg(REG_CHAIN_MODE, 8'($urandom_range(0, 1)));
            cfg_we  <= 1'b0;
            no_idle = ($urandom_range(0, 3) == 0);

            // expansion may be skipped only when enough round keys already exist
            if (sched_hi < 2 * rounds_cfg + 2 || $urandom_range(0, 3) != 0)
            begin
                for (k = 0; k < keylen_cfg; k++)
                begin
                    if (!key_written[k] || $urandom_range(0, 3) == 0)
                    begin
                        send_item(ACT_STORE, 8'(k), 8'($urandom_range(0, 255)),
                                  rand64(), rand64());
                    end
                end
                send_item(ACT_EXPAND, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          rand64(), rand64());
            end
            if ($urandom_range(0, 1))
            begin
                send_item(ACT_LOAD_IV, 8'd0, 8'd0, rand64(), rand64());
            end
            n = $urandom_range(4, 30);
            for (k = 0; k < n; k++)
            begin
                pick = $urandom_range(0, 15);
                if (pick < 6)
                begin
                    send_item(ACT_ENCRYPT, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), rand64(), rand64());
                end
                else if (pick < 12)
                begin
                    send_item(ACT_DECRYPT, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), rand64(), rand64());
                end
                else if (pick == 12)
                begin
                    send_item(ACT_LOAD_IV, 8'd0, 8'd0, rand64(), rand64());
                end
                else if (pick == 13)
                begin
                    // key store writes between blocks leave the schedule untouched
                    send_item(ACT_STORE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), rand64(), rand64());
                end
                else
                begin
                    send_item(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), rand64(), rand64());
                end
            end
        end

        // drain and let any trailing work finish
        in_ch.valid <= 1'b0;
        while (expected_blocks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (600) @(posedge clk);
        if (expected_blocks.size() != 0)
        begin
            report_mismatch("results missing", 64'd0, 64'(expected_blocks.size()));
        end
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
